>>> rtl/core/xedn_pkg.sv
// Shared constants, command codes and status bundle of the entity decoder.
package xedn_pkg;

    // '&' plus up to WIN-1 following bytes; the ';' must fall inside
    localparam int WIN        = 16;
    localparam int RING_AW    = $clog2(WIN);
    localparam int RING_DEPTH = 1 << RING_AW;
    localparam int FILL_W     = $clog2(WIN + 1);

    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_LOAD,
        CMD_SCAN,
        CMD_REPLAY,
        CMD_EMIT,
        CMD_FLUSH,
        CMD_END
    } cmd_t;

    typedef struct packed {
        logic eq_pend;    // decoded bytes wait for the normaliser
        logic unscanned;  // ring holds bytes not yet scanned
        logic held;       // an entity is open
        logic hold_v;     // a result waits in the hold stage
        logic can_put;    // hold stage can take a result this cycle
        logic out_free;   // output register can take a result this cycle
    } dp_status_t;

endpackage

>>> rtl/core/xedn_ctrl.sv
// Sequencer of the entity decoder: picks one datapath command per cycle.
module xedn_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    output logic                s_tready,
    input  xedn_pkg::dp_status_t st,
    output xedn_pkg::cmd_t      cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_WORK
    } state_t;

    state_t state_reg, state_next;
    logic   last_reg, last_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = xedn_pkg::CMD_IDLE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd        = xedn_pkg::CMD_LOAD;
                    last_next  = s_tlast;
                    state_next = ST_WORK;
                end
            end
            ST_WORK: begin
                if (st.eq_pend) begin
                    if (st.can_put) begin
                        cmd = xedn_pkg::CMD_EMIT;
                    end
                end else if (st.unscanned) begin
                    cmd = xedn_pkg::CMD_SCAN;
                end else if (last_reg && st.held) begin
                    cmd = xedn_pkg::CMD_REPLAY;
                end else if (last_reg) begin
                    if (st.out_free) begin
                        cmd        = xedn_pkg::CMD_END;
                        state_next = ST_IDLE;
                    end
                end else if (st.hold_v) begin
                    if (st.out_free) begin
                        cmd        = xedn_pkg::CMD_FLUSH;
                        state_next = ST_IDLE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

endmodule

>>> rtl/core/xedn_dp.sv
// Datapath: byte ring, entity recogniser, UTF-8 encoder, normaliser, output stage.
module xedn_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  xedn_pkg::cmd_t       cmd,
    input  logic [7:0]           in_byte,
    input  logic                 in_has,
    output xedn_pkg::dp_status_t st,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    localparam int AW = xedn_pkg::RING_AW;
    localparam int FW = xedn_pkg::FILL_W;
    localparam logic [16:0] ACC_SAT = 17'h10000;

    function automatic logic is_ws(input logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A;
    endfunction

    // name letter at index j of an upper-case name packed first letter high
    function automatic logic nm_hit(input logic [31:0] nm, input logic [2:0] len,
                                    input logic [7:0] u, input logic [FW-1:0] j);
        logic [1:0] sel;
        sel = len[1:0] - 2'd1 - j[1:0];
        return (j < FW'(len)) && (u == nm[8*sel +: 8]);
    endfunction

    logic [7:0]    buf_reg [xedn_pkg::RING_DEPTH];
    logic [AW-1:0] head_reg, head_next;
    logic [FW-1:0] tot_reg, tot_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [4:0]    nm_reg, nm_next;
    logic          hash_reg, hash_next;
    logic          hex_reg, hex_next;
    logic          bad_reg, bad_next;
    logic [16:0]   acc_reg, acc_next;
    logic [7:0]    e0_reg, e0_next, e1_reg, e1_next, e2_reg, e2_next;
    logic [1:0]    ecnt_reg, ecnt_next;
    logic          seen_reg, seen_next;
    logic          pend_reg, pend_next;
    logic          hold_v_reg, hold_v_next;
    logic [7:0]    hold_byte_reg, hold_byte_next;
    logic          out_v_reg, out_v_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          out_ok_reg, out_ok_next;
    logic          out_last_reg, out_last_next;

    logic [7:0]    c, u, put_byte;
    logic [FW-1:0] j, el, newfill;
    logic          do_put, x_case, is_dec, is_af, is_uaf, dig_ok;
    logic [3:0]    d;
    logic [20:0]   prod, sum;
    logic          name_ok, num_ok;
    logic [7:0]    name_char;

    assign c  = buf_reg[head_reg + fill_reg[AW-1:0]];
    assign u  = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    assign j  = fill_reg - FW'(1);
    assign el = fill_reg - FW'(1);
    assign newfill = fill_reg + FW'(1);

    assign x_case = (c == "x") || (c == "X");
    assign is_dec = (c >= "0") && (c <= "9");
    assign is_af  = (c >= "a") && (c <= "f");
    assign is_uaf = (c >= "A") && (c <= "F");
    assign dig_ok = is_dec || (hex_reg && (is_af || is_uaf));
    assign d      = is_dec ? 4'(c - "0") : is_af ? 4'(c - "a" + 8'd10) : 4'(c - "A" + 8'd10);
    assign prod   = hex_reg ? {acc_reg, 4'b0} : ({1'b0, acc_reg, 3'b0} + {3'b0, acc_reg, 1'b0});
    assign sum    = prod + {17'b0, d};

    always_comb begin
        name_ok   = 1'b1;
        name_char = "&";
        if (nm_reg[0] && el == FW'(3)) begin
            name_char = "&";
        end else if (nm_reg[1] && el == FW'(2)) begin
            name_char = "<";
        end else if (nm_reg[2] && el == FW'(2)) begin
            name_char = ">";
        end else if (nm_reg[3] && el == FW'(4)) begin
            name_char = "\"";
        end else if (nm_reg[4] && el == FW'(4)) begin
            name_char = "'";
        end else begin
            name_ok = 1'b0;
        end
    end
    assign num_ok = hash_reg && !bad_reg && acc_reg != 17'd0 && acc_reg < ACC_SAT;

    assign st.eq_pend   = ecnt_reg != 2'd0;
    assign st.unscanned = fill_reg != tot_reg;
    assign st.held      = fill_reg != FW'(0);
    assign st.hold_v    = hold_v_reg;
    assign st.out_free  = !out_v_reg || m_tready;
    assign st.can_put   = !hold_v_reg || !out_v_reg || m_tready;

    always_comb begin
        head_next      = head_reg;
        tot_next       = tot_reg;
        fill_next      = fill_reg;
        nm_next        = nm_reg;
        hash_next      = hash_reg;
        hex_next       = hex_reg;
        bad_next       = bad_reg;
        acc_next       = acc_reg;
        e0_next        = e0_reg;
        e1_next        = e1_reg;
        e2_next        = e2_reg;
        ecnt_next      = ecnt_reg;
        seen_next      = seen_reg;
        pend_next      = pend_reg;
        hold_v_next    = hold_v_reg;
        hold_byte_next = hold_byte_reg;
        out_v_next     = out_v_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_ok_next    = out_ok_reg;
        out_last_next  = out_last_reg;
        do_put         = 1'b0;
        put_byte       = e0_reg;
        case (cmd)
            xedn_pkg::CMD_LOAD: begin
                if (in_has) begin
                    tot_next = tot_reg + FW'(1);
                end
            end
            xedn_pkg::CMD_SCAN: begin
                if (fill_reg == FW'(0)) begin
                    if (c == "&") begin
                        fill_next = FW'(1);
                        nm_next   = 5'b11111;
                        hash_next = 1'b0;
                        hex_next  = 1'b0;
                        bad_next  = 1'b0;
                        acc_next  = 17'd0;
                    end else begin
                        e0_next   = c;
                        ecnt_next = 2'd1;
                        head_next = head_reg + AW'(1);
                        tot_next  = tot_reg - FW'(1);
                    end
                end else if (c == ";" && (name_ok || num_ok)) begin
                    // decoded: drop the whole entity from the ring
                    head_next = head_reg + newfill[AW-1:0];
                    tot_next  = tot_reg - newfill;
                    fill_next = FW'(0);
                    if (name_ok) begin
                        e0_next   = name_char;
                        ecnt_next = 2'd1;
                    end else if (acc_reg < 17'h80) begin
                        e0_next   = acc_reg[7:0];
                        ecnt_next = 2'd1;
                    end else if (acc_reg < 17'h800) begin
                        e0_next   = 8'hC0 | {3'b0, acc_reg[10:6]};
                        e1_next   = 8'h80 | {2'b0, acc_reg[5:0]};
                        ecnt_next = 2'd2;
                    end else begin
                        e0_next   = 8'hE0 | {4'b0, acc_reg[15:12]};
                        e1_next   = 8'h80 | {2'b0, acc_reg[11:6]};
                        e2_next   = 8'h80 | {2'b0, acc_reg[5:0]};
                        ecnt_next = 2'd3;
                    end
                end else if (c == ";" || fill_reg == FW'(xedn_pkg::WIN - 1)) begin
                    // not recognised: emit '&' and rescan what followed it
                    e0_next   = "&";
                    ecnt_next = 2'd1;
                    head_next = head_reg + AW'(1);
                    tot_next  = tot_reg - FW'(1);
                    fill_next = FW'(0);
                end else begin
                    fill_next  = newfill;
                    nm_next[0] = nm_reg[0] && nm_hit("AMP",  3'd3, u, j);
                    nm_next[1] = nm_reg[1] && nm_hit("LT",   3'd2, u, j);
                    nm_next[2] = nm_reg[2] && nm_hit("GT",   3'd2, u, j);
                    nm_next[3] = nm_reg[3] && nm_hit("QUOT", 3'd4, u, j);
                    nm_next[4] = nm_reg[4] && nm_hit("APOS", 3'd4, u, j);
                    if (j == FW'(0)) begin
                        hash_next = (c == "#");
                    end else if (j == FW'(1) && x_case) begin
                        hex_next = 1'b1;
                    end else if (hash_reg && !bad_reg) begin
                        if (!dig_ok) begin
                            bad_next = 1'b1;
                        end else begin
                            acc_next = (sum > {4'b0, ACC_SAT}) ? ACC_SAT : sum[16:0];
                        end
                    end
                end
            end
            xedn_pkg::CMD_REPLAY: begin
                e0_next   = "&";
                ecnt_next = 2'd1;
                head_next = head_reg + AW'(1);
                tot_next  = tot_reg - FW'(1);
                fill_next = FW'(0);
            end
            xedn_pkg::CMD_EMIT: begin
                if (is_ws(e0_reg)) begin
                    if (seen_reg) begin
                        pend_next = 1'b1;
                    end
                    e0_next   = e1_reg;
                    e1_next   = e2_reg;
                    ecnt_next = ecnt_reg - 2'd1;
                end else if (pend_reg) begin
                    do_put    = 1'b1;
                    put_byte  = 8'h20;
                    pend_next = 1'b0;
                end else begin
                    do_put    = 1'b1;
                    seen_next = 1'b1;
                    e0_next   = e1_reg;
                    e1_next   = e2_reg;
                    ecnt_next = ecnt_reg - 2'd1;
                end
            end
            xedn_pkg::CMD_FLUSH: begin
                out_v_next    = 1'b1;
                out_byte_next = hold_byte_reg;
                out_ok_next   = 1'b1;
                out_last_next = 1'b0;
                hold_v_next   = 1'b0;
            end
            xedn_pkg::CMD_END: begin
                out_v_next    = 1'b1;
                out_byte_next = hold_v_reg ? hold_byte_reg : 8'd0;
                out_ok_next   = hold_v_reg;
                out_last_next = 1'b1;
                hold_v_next   = 1'b0;
                seen_next     = 1'b0;
                pend_next     = 1'b0;
            end
            default: ;
        endcase
        if (do_put) begin
            if (hold_v_reg) begin
                out_v_next    = 1'b1;
                out_byte_next = hold_byte_reg;
                out_ok_next   = 1'b1;
                out_last_next = 1'b0;
            end
            hold_v_next    = 1'b1;
            hold_byte_next = put_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd == xedn_pkg::CMD_LOAD && in_has) begin
            buf_reg[head_reg + tot_reg[AW-1:0]] <= in_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            tot_reg    <= '0;
            fill_reg   <= '0;
            ecnt_reg   <= '0;
            seen_reg   <= 1'b0;
            pend_reg   <= 1'b0;
            hold_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            head_reg   <= head_next;
            tot_reg    <= tot_next;
            fill_reg   <= fill_next;
            ecnt_reg   <= ecnt_next;
            seen_reg   <= seen_next;
            pend_reg   <= pend_next;
            hold_v_reg <= hold_v_next;
            out_v_reg  <= out_v_next;
        end
        nm_reg        <= nm_next;
        hash_reg      <= hash_next;
        hex_reg       <= hex_next;
        bad_reg       <= bad_next;
        acc_reg       <= acc_next;
        e0_reg        <= e0_next;
        e1_reg        <= e1_next;
        e2_reg        <= e2_next;
        hold_byte_reg <= hold_byte_next;
        out_byte_reg  <= out_byte_next;
        out_ok_reg    <= out_ok_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tlast  = out_last_reg;

    a_fill_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= tot_reg)
        else $error("open entity longer than ring contents");

    a_scan_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == xedn_pkg::CMD_SCAN |-> ecnt_reg == 2'd0)
        else $error("scan issued while decoded bytes wait");

    a_end_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == xedn_pkg::CMD_END |=> out_v_reg && out_last_reg && !hold_v_reg)
        else $error("end of run not presented");

    a_end_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == xedn_pkg::CMD_END |-> tot_reg == '0 && ecnt_reg == 2'd0)
        else $error("end of run with bytes left");

endmodule

>>> rtl/core/xml_entity_decode_ws_normalize.sv
// Top level of the XML character-entity decoder with whitespace normalisation.
//
// Input channel (s_): one text byte per transaction. s_tuser flags that s_tdata
// carries a byte (low: bare end marker); s_tlast closes the text run.
// Output channel (m_): one decoded byte per transaction. m_tuser is the byte
// valid flag (low only on the empty final marker); m_tlast marks the final
// result of a run.
// Throughput: the input is taken only when the previous transaction has been
// fully worked off. A plain byte passes through accept, scan, emit and return;
// a byte inside an entity through accept, scan and return. An unrecognised
// entity emits '&' and rescans the held bytes through the sequencer, one scan
// step per cycle while no decoded byte waits for the normaliser.
// Each emitted byte uses one normaliser step, plus one for an inserted space.
// Latency: one result is held back in a hold stage so the run end can be put on
// the true final result; it is released at the end of each transaction.
// Reset: clears the ring pointers, the open entity, the whitespace flags and
// both result stages. A stalled receiver stops the normaliser once the hold
// stage and the output register are full; nothing is lost.
module xml_entity_decode_ws_normalize (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tuser,   // [0] has_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // [0] byte_valid
    output logic       m_tlast
);

    xedn_pkg::dp_status_t st;
    xedn_pkg::cmd_t       cmd;

    // sequencer: one command per cycle
    xedn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // ring, recogniser, normaliser and result stages
    xedn_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_byte  (s_tdata),
        .in_has   (s_tuser),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> tb/xml_entity_decode_ws_normalize_tb.sv
// Self-checking testbench for the XML entity decoder with whitespace normalisation.
`timescale 1ns / 100ps

// Mirror of the decoder's behaviour, with a queue of the output transactions it owes.
class decode_scoreboard;
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } out_beat_t;

    localparam int WINDOW = xedn_pkg::WIN;

    out_beat_t  owed[$];
    out_beat_t  step_q[$];
    logic [7:0] held[WINDOW];
    int         fill;
    bit         seen_text;
    bit         pending_space;
    int         errors;

    function new();
        fill = 0;
        seen_text = 0;
        pending_space = 0;
        errors = 0;
    endfunction

    function bit is_space(logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
    endfunction

    function void put(logic [7:0] b);
        out_beat_t r;
        r.data = b;
        r.valid = 1'b1;
        r.last = 1'b0;
        if (step_q.size() < 20) step_q.push_back(r);
    endfunction

    // Normalise whitespace on the decoded stream.
    function void normalise(logic [7:0] c);
        if (is_space(c)) begin
            if (seen_text) pending_space = 1;
            return;
        end
        if (pending_space) begin
            put(8'h20);
            pending_space = 0;
        end
        put(c);
        seen_text = 1;
    endfunction

    function logic [7:0] upper(logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function bit name_match(int len, string nm);
        if (len != nm.len()) return 0;
        for (int i = 0; i < len; i++)
            if (upper(held[i + 1]) != upper(nm[i])) return 0;
        return 1;
    endfunction

    // Held window is '&', body, ';'. Return 1 when decoded.
    function bit decode_entity();
        int          len;
        int          k;
        int unsigned radix;
        int unsigned acc;
        int unsigned dig;
        logic [7:0]  c;
        len = fill - 2;
        radix = 10;
        k = 1;
        acc = 0;
        if (name_match(len, "amp"))  begin normalise("&");  return 1; end
        if (name_match(len, "lt"))   begin normalise("<");  return 1; end
        if (name_match(len, "gt"))   begin normalise(">");  return 1; end
        if (name_match(len, "quot")) begin normalise(8'h22); return 1; end
        if (name_match(len, "apos")) begin normalise(8'h27); return 1; end
        if (len < 2 || held[1] != "#") return 0;
        if (held[2] == "x" || held[2] == "X") begin
            radix = 16;
            k = 2;
        end
        for (; k < len; k++) begin
            c = held[k + 1];
            if (c >= "0" && c <= "9") dig = c - "0";
            else if (radix == 16 && c >= "a" && c <= "f") dig = c - "a" + 10;
            else if (radix == 16 && c >= "A" && c <= "F") dig = c - "A" + 10;
            else begin
                acc = 0;
                break;
            end
            acc = acc * radix + dig;
            if (acc > 32'h10000) acc = 32'h10000;
        end
        if (acc > 0 && acc < 32'h80) begin
            normalise(acc[7:0]);
        end else if (acc >= 32'h80 && acc < 32'h800) begin
            normalise(8'hC0 | acc[10:6]);
            normalise(8'h80 | acc[5:0]);
        end else if (acc >= 32'h800 && acc < 32'h10000) begin
            normalise(8'hE0 | acc[15:12]);
            normalise(8'h80 | acc[11:6]);
            normalise(8'h80 | acc[5:0]);
        end else begin
            return 0;
        end
        return 1;
    endfunction

    // Emit '&' and push the held tail back in front of the pending bytes.
    function void rescan(ref logic [7:0] pend[$]);
        logic [7:0] tail[$];
        normalise("&");
        for (int i = 1; i < fill; i++) tail.push_back(held[i]);
        pend = {tail, pend};
        fill = 0;
    endfunction

    // Note one accepted input transaction and queue the output it causes.
    function void note_input(logic [7:0] b, bit has_byte, bit is_last);
        logic [7:0] pend[$];
        logic [7:0] c;
        out_beat_t  r;
        step_q.delete();
        if (has_byte) pend.push_back(b);
        forever begin
            if (pend.size() == 0) begin
                if (is_last && fill > 0) begin
                    rescan(pend);
                    continue;
                end
                break;
            end
            c = pend.pop_front();
            if (fill == 0) begin
                if (c == "&") begin
                    held[0] = c;
                    fill = 1;
                end else begin
                    normalise(c);
                end
                continue;
            end
            if (fill >= WINDOW) begin
                fill = 0;
                continue;
            end
            held[fill] = c;
            fill++;
            if (c == ";") begin
                if (decode_entity()) fill = 0;
                else rescan(pend);
            end else if (fill >= WINDOW) begin
                rescan(pend);
            end
        end
        if (is_last) begin
            pending_space = 0;
            seen_text = 0;
            fill = 0;
            if (step_q.size() == 0) begin
                r = '0;
                step_q.push_back(r);
            end
            step_q[step_q.size() - 1].last = 1'b1;
        end
        foreach (step_q[i]) owed.push_back(step_q[i]);
    endfunction

    function void report(string what);
        $display("MISMATCH %0t: %s", $time, what);
        errors++;
    endfunction

    // Compare one output transaction with the oldest owed result.
    function void check_output(logic [7:0] data, logic valid, logic last);
        out_beat_t e;
        if (owed.size() == 0) begin
            report($sformatf("unexpected output %h/%b/%b", data, valid, last));
            return;
        end
        e = owed.pop_front();
        if (data !== e.data)
            report($sformatf("out_byte %h, expected %h", data, e.data));
        if (valid !== e.valid)
            report($sformatf("byte_valid %b, expected %b", valid, e.valid));
        if (last !== e.last)
            report($sformatf("run_end %b, expected %b", last, e.last));
    endfunction
endclass

module xml_entity_decode_ws_normalize_tb;

    localparam int CYCLE_LIMIT = 400000;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tuser;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    decode_scoreboard sb;

    // Idle rates in percent; stall_hold forces a long receiver hold-off.
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  stall_hold;
    int  cycles = 0;
    bit  stim_done;

    xml_entity_decode_ws_normalize dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] in_byte
        .s_tuser  (s_tuser),   // [0] has_byte
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [7:0] out_byte
        .m_tuser  (m_tuser),   // [0] byte_valid
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Watchdog: end the run as failed once the cycle counter passes CYCLE_LIMIT.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("xml_entity_decode_ws_normalize verification failed");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus the forced long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) sb.check_output(m_tdata, m_tuser, m_tlast);
            m_tready <= !stall_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one input transaction, with a random gap before it; hold until taken.
    task automatic send_byte(logic [7:0] b, bit has_byte, bit is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= has_byte;
        s_tlast  <= is_last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(b, has_byte, is_last);
    endtask

    // Drop the valid after the last offered transaction and wait for the next clock edge.
    task automatic end_stream();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_text(string txt, bit close_run);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i], 1'b1, close_run && i == txt.len() - 1);
    endtask

    // Wait until every owed result has come back.
    task automatic drain();
        while (sb.owed.size() != 0) @(posedge aclk);
    endtask

    // Pick one random byte, biased towards entity syntax and whitespace.
    function automatic logic [7:0] pick_byte();
        string alpha;
        alpha = "&;#xXaAmMpPlLtTgGqQuUoOsS0123456789abcdefF \t\r\n";
        case ($urandom_range(3))
            0: return 8'($urandom_range(255));
            default: return alpha[$urandom_range(alpha.len() - 1)];
        endcase
    endfunction

    // Build one well-formed (or mildly broken) entity with random content.
    function automatic string make_entity();
        string names[5];
        string s;
        int    n;
        names = '{"amp", "lt", "gt", "quot", "apos"};
        case ($urandom_range(4))
            0: begin
                s = names[$urandom_range(4)];
                for (int i = 0; i < s.len(); i++)
                    if ($urandom_range(1)) s[i] = s[i] - 8'd32;
                s = {"&", s, ";"};
            end
            1: s = $sformatf("&#%0d;", $urandom_range(70000));
            2: s = $sformatf("&#%s%0h;", $urandom_range(1) ? "x" : "X",
                             $urandom_range(1) ? $urandom_range(255) : $urandom_range(70000));
            3: s = $sformatf("&#%0d;", 1 + $urandom_range(126));
            default: begin
                // broken: random body, possibly never closed
                n = $urandom_range(17);
                s = "&";
                for (int i = 0; i < n; i++) s = {s, string'(pick_byte())};
            end
        endcase
        return s;
    endfunction

    // Random runs: entities and plain text mixed, closed by a marker or last byte.
    task automatic random_runs(int budget);
        int    sent;
        int    run_len;
        string frag;
        sent = 0;
        while (sent < budget) begin
            run_len = $urandom_range(1, 12);
            for (int i = 0; i < run_len; i++) begin
                if ($urandom_range(9) < 6) frag = make_entity();
                else frag = string'(pick_byte());
                send_text(frag, 1'b0);
                sent += frag.len();
            end
            if ($urandom_range(1)) send_byte(8'($urandom_range(255)), 1'b0, 1'b1);
            else send_byte(pick_byte(), 1'b1, 1'b1);
            sent++;
        end
        end_stream();
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        stall_hold = 1'b0;
        send_idle_pct = 8;
        recv_idle_pct = 84;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: named entities in any case, numeric forms, UTF-8 lengths,
        // zero and out-of-range values, window overflow and run-end flushes.
        send_text("  a&AmP;&lt;&Gt;&quot;&APOS;  \t b ", 1'b0);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_text("&#65;&#x41;&#xe9;&#x20AC;&#0;&#65536;&#x;&#;&#1a;&#32;x", 1'b1);
        send_text("&abcdefghijklmnop;q&bogus;&#x10000;", 1'b1);
        send_byte(8'h00, 1'b0, 1'b1);
        send_text("\r\n ", 1'b0);
        send_byte(8'h55, 1'b0, 1'b1);
        send_text("x&am", 1'b0);
        send_byte(8'hAA, 1'b0, 1'b1);
        send_text("&&lt;\x80", 1'b1);
        end_stream();
        drain();

        // Sender idles lightly, receiver heavily.
        random_runs(80);

        // Long receiver hold-off while the sender keeps offering.
        fork
            begin
                stall_hold = 1'b1;
                repeat (300) @(posedge aclk);
                stall_hold = 1'b0;
            end
            random_runs(30);
        join
        // Sender pauses until the decoder is fully drained.
        drain();

        send_idle_pct = 84;
        recv_idle_pct = 8;
        random_runs(70);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_runs(80);

        drain();
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("xml_entity_decode_ws_normalize verification clean");
        end else begin
            $display("xml_entity_decode_ws_normalize verification failed");
        end
        $finish;
    end
endmodule
